// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int unsigned ItemBits = 32;
  localparam int unsigned PrioBits = 16;
  localparam int unsigned OccBits  = 5;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [ItemBits-1:0] item_in;
    logic signed [PrioBits-1:0] priority_in;
  } req_t;

  typedef struct packed {
    logic signed [ItemBits-1:0] item_out;
    logic [1:0]                 status;
    logic                       empty_flag;
    logic [OccBits-1:0]         occupancy;
  } rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_e                       kind;
    logic signed [ItemBits-1:0] item;
    logic signed [PrioBits-1:0] prio;
  } op_t;

endpackage

// ===== sv/spq_front.sv =====
module spq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::req_t req_i,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  output spq_pkg::op_t  op_o,
  output logic          op_valid_o,
  input  logic          op_pop_i
);
  import spq_pkg::*;

  op_t        mem_q [2];
  op_t        op_new;
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic       push;

  always_comb begin
    op_new.item = req_i.item_in;
    op_new.prio = req_i.priority_in;
    case (req_i.command)
      CMD_ENQ:  op_new.kind = CMD_ENQ;
      CMD_DEQ:  op_new.kind = CMD_DEQ;
      CMD_PEEK: op_new.kind = CMD_PEEK;
      default:  op_new.kind = CMD_NOP;
    endcase
  end

  assign req_stall_o = (cnt_q == 2'd2);
  assign push        = req_valid_i && !req_stall_o;
  assign op_valid_o  = (cnt_q != 2'd0);
  assign op_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = op_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (push && !op_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && op_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q  <= wr_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= op_new;
    end
  end

endmodule

// ===== sv/spq_back.sv =====
module spq_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::op_t  op_i,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  output spq_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i
);
  import spq_pkg::*;

  localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);

  logic signed [ItemBits-1:0] itm_q  [QUEUE_DEPTH];
  logic signed [PrioBits-1:0] prio_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]     ge;
  logic [CntBits-1:0]         cnt_q, cnt_d;
  logic                       full, empty;
  logic                       do_ins, do_rem;
  logic                       vld_q;
  rsp_t                       rsp_q, rsp_d;

  assign full     = (cnt_q == CntBits'(QUEUE_DEPTH));
  assign empty    = (cnt_q == '0);
  assign op_pop_o = op_valid_i && (!vld_q || !rsp_stall_i);
  assign do_ins   = op_pop_o && (op_i.kind == CMD_ENQ) && !full;
  assign do_rem   = op_pop_o && (op_i.kind == CMD_DEQ) && !empty;

  always_comb begin
    cnt_d              = cnt_q;
    rsp_d.item_out     = '0;
    rsp_d.status       = ST_OK;
    case (op_i.kind)
      CMD_ENQ: begin
        if (full) begin
          rsp_d.status = ST_OVER;
        end else begin
          cnt_d = cnt_q + CntBits'(1);
        end
      end
      CMD_DEQ: begin
        if (empty) begin
          rsp_d.status = ST_UNDER;
        end else begin
          rsp_d.item_out = itm_q[0];
          cnt_d          = cnt_q - CntBits'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          rsp_d.status   = ST_UNDER;
          rsp_d.item_out = '1;
        end else begin
          rsp_d.item_out = itm_q[0];
        end
      end
      default: ;
    endcase
    rsp_d.empty_flag = (cnt_d == '0);
    rsp_d.occupancy  = OccBits'(cnt_d);
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic take_new;

    // entries at or above the new priority stay ahead of it
    assign ge[i] = (CntBits'(i) < cnt_q) && (prio_q[i] >= op_i.prio);

    if (i == 0) begin : g_head
      assign take_new = 1'b1;
    end else begin : g_body
      assign take_new = ge[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins && !ge[i]) begin
        if (take_new) begin
          itm_q[i]  <= op_i.item;
          prio_q[i] <= op_i.prio;
        end else begin
          itm_q[i]  <= itm_q[(i > 0) ? i-1 : 0];
          prio_q[i] <= prio_q[(i > 0) ? i-1 : 0];
        end
      end else if (do_rem && (i < QUEUE_DEPTH - 1)) begin
        itm_q[i]  <= itm_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        prio_q[i] <= prio_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (op_pop_o) begin
        cnt_q <= cnt_d;
        vld_q <= 1'b1;
      end else if (!rsp_stall_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = vld_q;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// Path: an accepted request is written into the front queue, then the cell update
// and the output register take it from there.
// Throughput: one request per cycle while no stall holds it; an insert or removal
// updates every shift-register cell in parallel, with the output register after it.
// Reset: asynchronous, active low; occupancy cleared to empty, queues and output
// register emptied. Cell contents are not cleared.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::req_t req_i,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  output spq_pkg::rsp_t rsp_o,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i
);
  import spq_pkg::*;

  op_t  op;
  logic op_valid;
  logic op_pop;

  spq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .op_o        (op),
    .op_valid_o  (op_valid),
    .op_pop_i    (op_pop)
  );

  spq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .op_valid_i  (op_valid),
    .op_pop_o    (op_pop),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i)
  );

endmodule

// ===== sv/spq_checker.sv =====
module spq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid_i,
  input logic          rsp_stall_i,
  input spq_pkg::rsp_t rsp_i
);
  import spq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_stall_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("stalled result changed");

  a_under_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == ST_UNDER) |-> rsp_i.empty_flag)
    else $error("underflow on non-empty queue");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == ST_OVER) |-> !rsp_i.empty_flag && (rsp_i.item_out == '0))
    else $error("overflow with empty queue or nonzero item");

  a_under_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_i.status == ST_UNDER) |-> (rsp_i.item_out == '0) || (rsp_i.item_out == '1))
    else $error("bad item on underflow");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_valid_o),
  .rsp_stall_i (rsp_stall_i),
  .rsp_i       (rsp_o)
);

// ===== bench/sorted_priority_queue_test.sv =====
`timescale 1ns / 100ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int Depth    = 16;
  localparam int RandReqs = 650;
  localparam int MaxWait  = 12;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  req_t  req_i       = '0;
  logic  req_valid_i = 1'b0;
  logic  req_stall_o;
  rsp_t  rsp_o;
  logic  rsp_valid_o;
  logic  rsp_stall_i = 1'b0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .req_valid_i(req_valid_i),
    .req_stall_o(req_stall_o),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .rsp_stall_i(rsp_stall_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the sorted store, front at index 0
  logic signed [ItemBits-1:0] held_items [Depth];
  logic signed [PrioBits-1:0] held_prios [Depth];
  int held_count = 0;

  req_t cmd_stream  [$];
  rsp_t due_replies [$];

  int n_total     = 0;
  int n_req_sent  = 0;
  int n_req_taken = 0;
  int n_rsp_taken = 0;
  int n_rsp_last  = 0;
  int send_wait   = 0;
  int stall_left  = 0;
  int n_mismatch  = 0;
  int n_stray     = 0;
  int n_overflow  = 0;
  int n_underflow = 0;
  int peak_count  = 0;

  function automatic rsp_t sorted_apply(input req_t rq);
    rsp_t rs;
    int   pos;
    rs = '0;
    rs.status = ST_OK;
    case (cmd_e'(rq.command))
      CMD_ENQ: begin
        if (held_count >= Depth) begin
          rs.status = ST_OVER;
          n_overflow++;
        end else begin
          pos = 0;
          while (pos < held_count && held_prios[pos] >= rq.priority_in) pos++;
          for (int k = held_count; k > pos; k--) begin
            held_items[k] = held_items[k-1];
            held_prios[k] = held_prios[k-1];
          end
          held_items[pos] = rq.item_in;
          held_prios[pos] = rq.priority_in;
          held_count++;
          if (held_count > peak_count) peak_count = held_count;
        end
      end
      CMD_DEQ: begin
        if (held_count == 0) begin
          rs.status = ST_UNDER;
          n_underflow++;
        end else begin
          rs.item_out = held_items[0];
          for (int k = 1; k < held_count; k++) begin
            held_items[k-1] = held_items[k];
            held_prios[k-1] = held_prios[k];
          end
          held_count--;
        end
      end
      CMD_PEEK: begin
        if (held_count == 0) begin
          rs.status   = ST_UNDER;
          rs.item_out = '1;
          n_underflow++;
        end else begin
          rs.item_out = held_items[0];
        end
      end
      default: ;
    endcase
    rs.empty_flag = (held_count == 0);
    rs.occupancy  = OccBits'(held_count);
    return rs;
  endfunction

  function automatic int pick_wait(input bit busy);
    if (!busy || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  task automatic add_req(input cmd_e c, input logic [ItemBits-1:0] it,
                         input logic [PrioBits-1:0] pr);
    req_t rq;
    rq.command     = c;
    rq.item_in     = it;
    rq.priority_in = pr;
    cmd_stream.push_back(rq);
  endtask

  // request driver
  always @(negedge clk_i) begin
    req_t next_req;
    logic next_valid;
    next_req   = req_i;
    next_valid = req_valid_i;
    if (rst_ni && !(req_valid_i && n_req_taken != n_req_sent)) begin
      next_valid = 1'b0;
      if (send_wait > 0) begin
        send_wait--;
      end else if (cmd_stream.size() != 0) begin
        next_req   = cmd_stream.pop_front();
        next_valid = 1'b1;
        n_req_sent++;
        send_wait  = pick_wait(((n_req_sent / 64) % 4) != 1);
      end
    end
    req_i       <= next_req;
    req_valid_i <= next_valid;
  end

  // result stall
  always @(negedge clk_i) begin
    logic hold;
    if (n_rsp_last != n_rsp_taken) begin
      n_rsp_last = n_rsp_taken;
      stall_left = pick_wait(((n_rsp_taken / 64) % 4) != 3);
    end
    hold = (stall_left > 0);
    if (hold) stall_left--;
    rsp_stall_i <= hold;
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        n_rsp_taken++;
        if (due_replies.size() == 0) begin
          n_stray++;
          if (n_mismatch + n_stray <= 10)
            $display("unexpected result: item %h status %0d empty %0b occ %0d",
                     rsp_o.item_out, rsp_o.status, rsp_o.empty_flag, rsp_o.occupancy);
        end else begin
          want = due_replies.pop_front();
          if (rsp_o.item_out !== want.item_out || rsp_o.status !== want.status ||
              rsp_o.empty_flag !== want.empty_flag || rsp_o.occupancy !== want.occupancy) begin
            n_mismatch++;
            if (n_mismatch + n_stray <= 10)
              $display({"result %0d mismatch: exp item %h st %0d empty %0b occ %0d,",
                        " got item %h st %0d empty %0b occ %0d"},
                       n_rsp_taken, want.item_out, want.status, want.empty_flag,
                       want.occupancy, rsp_o.item_out, rsp_o.status, rsp_o.empty_flag,
                       rsp_o.occupancy);
          end
        end
      end
      if (req_valid_i && !req_stall_o) begin
        n_req_taken++;
        due_replies.push_back(sorted_apply(req_i));
      end
    end
  end

  initial begin
    int mode;
    int seg;
    int enq_pct;
    int r;
    int sel;
    int n_rand;
    logic [PrioBits-1:0] pr;

    // empty cases and the unused code
    add_req(CMD_PEEK, 32'h1234_5678, 16'h0001);
    add_req(CMD_DEQ, 32'h8765_4321, 16'hfffe);
    add_req(CMD_NOP, 32'hffff_ffff, 16'hffff);
    // extremes, ties at zero and at the top priority
    add_req(CMD_ENQ, 32'h7fff_ffff, 16'h0000);
    add_req(CMD_ENQ, 32'h8000_0000, 16'h7fff);
    add_req(CMD_ENQ, 32'h0000_0000, 16'h8000);
    add_req(CMD_ENQ, 32'hffff_ffff, 16'h0000);
    add_req(CMD_ENQ, 32'h0000_0001, 16'hffff);
    add_req(CMD_ENQ, 32'ha5a5_a5a5, 16'h7fff);
    for (int i = 0; i < 10; i++) add_req(CMD_ENQ, 32'h100 + i, PrioBits'(i % 3));
    // full queue
    add_req(CMD_ENQ, 32'hdead_beef, 16'h7fff);
    add_req(CMD_PEEK, 32'h0, 16'h0);
    add_req(CMD_DEQ, 32'h0, 16'h0);
    add_req(CMD_DEQ, 32'h5a5a_5a5a, 16'h5a5a);
    add_req(CMD_DEQ, 32'h0, 16'h0);

    // random bursts that lean toward filling, draining, or neither
    n_rand = 0;
    while (n_rand < RandReqs) begin
      mode    = $urandom_range(0, 2);
      seg     = $urandom_range(8, 40);
      enq_pct = (mode == 0) ? 62 : (mode == 1) ? 20 : 40;
      repeat (seg) begin
        r   = $urandom_range(0, 99);
        sel = $urandom_range(0, 9);
        if (sel < 6)      pr = PrioBits'($urandom_range(0, 6) - 3);
        else if (sel < 8) pr = PrioBits'($urandom);
        else              pr = sel[0] ? 16'h7fff : 16'h8000;
        if (r < 3)                 add_req(CMD_NOP, $urandom, pr);
        else if (r < 18)           add_req(CMD_PEEK, $urandom, pr);
        else if (r < 18 + enq_pct) add_req(CMD_ENQ, $urandom, pr);
        else                       add_req(CMD_DEQ, $urandom, pr);
        n_rand++;
      end
    end
    n_total = cmd_stream.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_req_taken != n_total || due_replies.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("covered %0d requests and %0d results; %0d overflows, %0d underflows",
             n_req_taken, n_rsp_taken, n_overflow, n_underflow);
    $display("peak occupancy %0d of %0d; %0d mismatches, %0d stray results",
             peak_count, Depth, n_mismatch, n_stray);
    if (n_mismatch == 0 && n_stray == 0 && due_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0d of %0d requests, %0d results", n_req_taken, n_total,
             n_rsp_taken);
    $display("status: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/spq_pkg.sv
sv/spq_front.sv
sv/spq_back.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
bench/sorted_priority_queue_test.sv
